>>> rtl/aws_pkg.sv
package aws_pkg;

    // Default values of the top-level parameters.
    localparam int OFFSET_COUNT_DEF = 12;
    localparam int PASS_COUNT_DEF   = 3;
    localparam int SAMPLE_BITS_DEF  = 12;

    // Fixed field widths.
    localparam int ADC_BITS    = 12;
    localparam int PASS_BITS   = 2;
    localparam int OFFSET_BITS = 4;
    localparam int TICK_BITS   = 10;
    localparam int COUNT_BITS  = 16;
    localparam int SUM_BITS    = 28;
    localparam int HALF_US_BITS = 5;

    localparam logic [5:0] TICKS_PER_HALF_US = 6'd48;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAT_LOW  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAT_HIGH = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW   = 2'd2;

    localparam logic [ADC_BITS-1:0]   SAT_LOW_RESET  = 12'd50;
    localparam logic [ADC_BITS-1:0]   SAT_HIGH_RESET = 12'd4045;
    localparam logic [COUNT_BITS-1:0] WINDOW_RESET   = 16'd128;

    // Request kinds carried on the input side-band.
    localparam logic REQ_SAMPLE   = 1'b0;
    localparam logic REQ_SNAPSHOT = 1'b1;

    // Queue between the classifier and the accumulator.
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    typedef struct packed {
        logic [ADC_BITS-1:0]   low_thresh;
        logic [ADC_BITS-1:0]   high_thresh;
        logic [COUNT_BITS-1:0] window;
    } cfg_t;

    // One classified input item.
    typedef struct packed {
        logic                is_snap;
        logic [ADC_BITS-1:0] value;
        logic                low_sat;
        logic                high_sat;
        logic                high_side;
        logic                low_side;
    } item_t;

    typedef struct packed {
        logic [PASS_BITS-1:0]   pass_number;
        logic [OFFSET_BITS-1:0] offset_number;
        logic [TICK_BITS-1:0]   window_ticks;
        logic [TICK_BITS-1:0]   next_ticks;
        logic [ADC_BITS-1:0]    sample_min;
        logic [ADC_BITS-1:0]    sample_max;
        logic [SUM_BITS-1:0]    sample_sum;
        logic [COUNT_BITS-1:0]  low_sat_count;
        logic [COUNT_BITS-1:0]  high_sat_count;
        logic [COUNT_BITS-1:0]  high_side_count;
        logic [COUNT_BITS-1:0]  low_side_count;
        logic                   sweep_done;
    } result_t;

    // Trigger offsets in half microseconds; entries past the list are zero.
    function automatic logic [HALF_US_BITS-1:0] trigger_half_us(
        input logic [OFFSET_BITS-1:0] idx
    );
        logic [HALF_US_BITS-1:0] hu;
        case (idx)
            4'd0:    hu = 5'd1;
            4'd1:    hu = 5'd2;
            4'd2:    hu = 5'd4;
            4'd3:    hu = 5'd6;
            4'd4:    hu = 5'd8;
            4'd5:    hu = 5'd10;
            4'd6:    hu = 5'd11;
            4'd7:    hu = 5'd12;
            4'd8:    hu = 5'd13;
            4'd9:    hu = 5'd14;
            4'd10:   hu = 5'd16;
            4'd11:   hu = 5'd20;
            default: hu = 5'd0;
        endcase
        return hu;
    endfunction

    function automatic logic [TICK_BITS-1:0] ticks_of(input logic [OFFSET_BITS-1:0] idx);
        logic [10:0] prod;
        prod = 11'(trigger_half_us(idx)) * 11'(TICKS_PER_HALF_US);
        return prod[TICK_BITS-1:0];
    endfunction

endpackage

>>> rtl/adc_window_stats_sweeper.sv
// Channel   | Direction | Group                     | Contents
// ----------+-----------+---------------------------+-------------------------------------
// input     | in        | s_tvalid/s_tready/s_tdata | sample or pin snapshot, kind on s_tuser
// result    | out       | m_tvalid/m_tready/m_tdata | window statistics, sweep end on m_tlast
// config    | in        | cfg_we/cfg_index/cfg_data | threshold and window size registers
//
// A new input transfer can be taken every cycle, and the result register decouples the
// output so that a stalled result blocks input only once the four-entry queue and the
// front register are full.
// The input transfer that closes a window loads the front register, then the queue; when
// it leaves the queue it loads the result register, which raises result valid.
// Reset clears the sweep to pass 0, offset 0 with an empty window; there is no clearing pass.
// After the last window of the last pass the block keeps taking transfers and drops them.
module adc_window_stats_sweeper #(
    parameter int OFFSET_COUNT = aws_pkg::OFFSET_COUNT_DEF,
    parameter int PASS_COUNT   = aws_pkg::PASS_COUNT_DEF,
    parameter int SAMPLE_BITS  = aws_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // adc_value[11:0], high_side_level[12], low_side_level[13], zero fill [15:14]
    input  logic [15:0]                           s_tdata,
    // req_type
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // pass_number[1:0], offset_number[5:2], window_ticks[15:6], next_ticks[25:16],
    // sample_min[37:26], sample_max[49:38], sample_sum[77:50], low_sat_count[93:78],
    // high_sat_count[109:94], high_side_count[125:110], low_side_count[141:126],
    // zero fill [143:142]
    output logic [143:0]                          m_tdata,
    // sweep_done
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [aws_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [aws_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    aws_pkg::cfg_t    cfg_reg;
    logic             item_valid;
    logic             item_ready;
    aws_pkg::item_t   front_item;
    logic             q_valid;
    logic             q_ready;
    aws_pkg::item_t   q_item;
    aws_pkg::result_t res;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_thresh  <= aws_pkg::SAT_LOW_RESET;
            cfg_reg.high_thresh <= aws_pkg::SAT_HIGH_RESET;
            cfg_reg.window      <= aws_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aws_pkg::CFG_SAT_LOW:  cfg_reg.low_thresh  <= cfg_data[aws_pkg::ADC_BITS-1:0];
                aws_pkg::CFG_SAT_HIGH: cfg_reg.high_thresh <= cfg_data[aws_pkg::ADC_BITS-1:0];
                aws_pkg::CFG_WINDOW:   cfg_reg.window      <= cfg_data;
                default:               ;
            endcase
        end
    end

    // The front register classifies each transfer and grades samples against the
    // thresholds, so the accumulator only has to add, compare and count.
    aws_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .req_type        (s_tuser),
        .adc_value       (s_tdata[11:0]),
        .high_side_level (s_tdata[12]),
        .low_side_level  (s_tdata[13]),
        .cfg             (cfg_reg),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item            (front_item)
    );

    aws_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (item_valid),
        .push_ready (item_ready),
        .push_item  (front_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // The back end owns the window accumulators, the sweep position and the result register.
    aws_back #(
        .OFFSET_COUNT (OFFSET_COUNT),
        .PASS_COUNT   (PASS_COUNT),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {2'b00,
                      res.low_side_count,
                      res.high_side_count,
                      res.high_sat_count,
                      res.low_sat_count,
                      res.sample_sum,
                      res.sample_max,
                      res.sample_min,
                      res.next_ticks,
                      res.window_ticks,
                      res.offset_number,
                      res.pass_number};
    assign m_tlast = res.sweep_done;

endmodule

>>> rtl/aws_front.sv
module aws_front #(
    parameter int SAMPLE_BITS = aws_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [aws_pkg::ADC_BITS-1:0]  adc_value,
    input  logic                          high_side_level,
    input  logic                          low_side_level,
    input  aws_pkg::cfg_t                 cfg,
    output logic                          item_valid,
    input  logic                          item_ready,
    output aws_pkg::item_t                item
);

    localparam logic [aws_pkg::ADC_BITS-1:0] SAMPLE_MASK =
        (SAMPLE_BITS >= aws_pkg::ADC_BITS) ? {aws_pkg::ADC_BITS{1'b1}}
                                           : aws_pkg::ADC_BITS'((1 << SAMPLE_BITS) - 1);

    logic           valid_reg;
    aws_pkg::item_t item_reg;
    aws_pkg::item_t item_next;

    // Mask the sample and grade it against the saturation thresholds.
    always_comb
    begin
        item_next.is_snap   = (req_type == aws_pkg::REQ_SNAPSHOT);
        item_next.value     = adc_value & SAMPLE_MASK;
        item_next.low_sat   = (item_next.value <= cfg.low_thresh);
        item_next.high_sat  = (item_next.value >= cfg.high_thresh);
        item_next.high_side = high_side_level;
        item_next.low_side  = low_side_level;
    end

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> rtl/aws_queue.sv
module aws_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  aws_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output aws_pkg::item_t pop_item
);

    aws_pkg::item_t                         entry_reg [aws_pkg::QUEUE_DEPTH];
    logic [aws_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_reg;
    logic [aws_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_reg;
    logic [aws_pkg::QUEUE_CNT_BITS-1:0]     count_reg;
    logic [aws_pkg::QUEUE_CNT_BITS-1:0]     count_next;
    logic                                   push;
    logic                                   pop;

    assign push_ready = (count_reg != aws_pkg::QUEUE_CNT_BITS'(aws_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= aws_pkg::QUEUE_CNT_BITS'(aws_pkg::QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone write");

endmodule

>>> rtl/aws_back.sv
module aws_back #(
    parameter int OFFSET_COUNT = aws_pkg::OFFSET_COUNT_DEF,
    parameter int PASS_COUNT   = aws_pkg::PASS_COUNT_DEF,
    parameter int SAMPLE_BITS  = aws_pkg::SAMPLE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  aws_pkg::cfg_t    cfg,
    input  logic             item_valid,
    output logic             item_ready,
    input  aws_pkg::item_t   item,
    output logic             res_valid,
    input  logic             res_ready,
    output aws_pkg::result_t res
);

    localparam int AB = aws_pkg::ADC_BITS;
    localparam int CB = aws_pkg::COUNT_BITS;
    localparam int SB = aws_pkg::SUM_BITS;
    localparam int PB = aws_pkg::PASS_BITS;
    localparam int OB = aws_pkg::OFFSET_BITS;

    localparam logic [AB-1:0] SAMPLE_MASK =
        (SAMPLE_BITS >= AB) ? {AB{1'b1}} : AB'((1 << SAMPLE_BITS) - 1);
    localparam logic [OB:0]   OFFSET_LIMIT = (OB+1)'(OFFSET_COUNT);
    localparam logic [PB:0]   PASS_LIMIT   = (PB+1)'(PASS_COUNT);

    logic            running_reg;
    logic [PB-1:0]   pass_reg;
    logic [OB-1:0]   offset_reg;
    logic [CB-1:0]   count_reg;
    logic [AB-1:0]   min_reg;
    logic [AB-1:0]   max_reg;
    logic [SB-1:0]   sum_reg;
    logic [CB-1:0]   low_sat_reg;
    logic [CB-1:0]   high_sat_reg;
    logic [CB-1:0]   high_side_reg;
    logic [CB-1:0]   low_side_reg;

    logic            out_valid_reg;
    aws_pkg::result_t out_reg;

    logic            pop;
    logic            take_sample;
    logic            take_snap;
    logic            close;
    logic            emit;
    logic            last_offset;
    logic            last_pass;
    logic [CB:0]     count_inc;
    logic [AB-1:0]   min_next;
    logic [AB-1:0]   max_next;
    logic [SB:0]     sum_add;
    logic [SB-1:0]   sum_next;
    logic [CB-1:0]   low_sat_next;
    logic [CB-1:0]   high_sat_next;
    logic [CB-1:0]   high_side_next;
    logic [CB-1:0]   low_side_next;
    aws_pkg::result_t res_next;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] c, input logic en);
        logic [CB-1:0] r;
        r = c;
        if (en && (c != {CB{1'b1}}))
        begin
            r = c + 1'b1;
        end
        return r;
    endfunction

    assign item_ready  = !out_valid_reg || res_ready;
    assign pop         = item_valid && item_ready;
    assign take_sample = pop && running_reg && !item.is_snap;
    assign take_snap   = pop && running_reg && item.is_snap;

    always_comb
    begin
        count_inc      = {1'b0, count_reg} + 1'b1;
        close          = (count_inc >= {1'b0, cfg.window});
        emit           = take_sample && close;
        min_next       = (item.value < min_reg) ? item.value : min_reg;
        max_next       = (item.value > max_reg) ? item.value : max_reg;
        sum_add        = {1'b0, sum_reg} + (SB+1)'(item.value);
        sum_next       = sum_add[SB] ? {SB{1'b1}} : sum_add[SB-1:0];
        low_sat_next   = sat_inc(low_sat_reg, item.low_sat);
        high_sat_next  = sat_inc(high_sat_reg, item.high_sat);
        high_side_next = sat_inc(high_side_reg, item.high_side);
        low_side_next  = sat_inc(low_side_reg, item.low_side);
        last_offset    = (({1'b0, offset_reg} + 1'b1) >= OFFSET_LIMIT);
        last_pass      = (({1'b0, pass_reg} + 1'b1) >= PASS_LIMIT);

        res_next.pass_number     = pass_reg;
        res_next.offset_number   = offset_reg;
        res_next.window_ticks    = aws_pkg::ticks_of(offset_reg);
        res_next.sample_min      = min_next;
        res_next.sample_max      = max_next;
        res_next.sample_sum      = sum_next;
        res_next.low_sat_count   = low_sat_next;
        res_next.high_sat_count  = high_sat_next;
        res_next.high_side_count = high_side_reg;
        res_next.low_side_count  = low_side_reg;
        res_next.sweep_done      = last_offset && last_pass;
        if (!last_offset)
        begin
            res_next.next_ticks = aws_pkg::ticks_of(offset_reg + 1'b1);
        end
        else if (!last_pass)
        begin
            res_next.next_ticks = aws_pkg::ticks_of('0);
        end
        else
        begin
            res_next.next_ticks = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b1;
            pass_reg      <= '0;
            offset_reg    <= '0;
            count_reg     <= '0;
            min_reg       <= SAMPLE_MASK;
            max_reg       <= '0;
            sum_reg       <= '0;
            low_sat_reg   <= '0;
            high_sat_reg  <= '0;
            high_side_reg <= '0;
            low_side_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (take_snap)
            begin
                high_side_reg <= high_side_next;
                low_side_reg  <= low_side_next;
            end

            if (emit)
            begin
                // The window is closed: clear it and step the sweep.
                count_reg     <= '0;
                min_reg       <= SAMPLE_MASK;
                max_reg       <= '0;
                sum_reg       <= '0;
                low_sat_reg   <= '0;
                high_sat_reg  <= '0;
                high_side_reg <= '0;
                low_side_reg  <= '0;
                if (last_offset && last_pass)
                begin
                    running_reg <= 1'b0;
                end
                else if (!last_offset)
                begin
                    offset_reg <= offset_reg + 1'b1;
                end
                else
                begin
                    offset_reg <= '0;
                    pass_reg   <= pass_reg + 1'b1;
                end
            end
            else if (take_sample)
            begin
                count_reg    <= count_inc[CB-1:0];
                min_reg      <= min_next;
                max_reg      <= max_next;
                sum_reg      <= sum_next;
                low_sat_reg  <= low_sat_next;
                high_sat_reg <= high_sat_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, offset_reg} < OFFSET_LIMIT) && ({1'b0, pass_reg} < PASS_LIMIT))
        else $error("sweep position out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res_next.sweep_done) |=> !running_reg)
        else $error("sweep still running after final window");

    assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |=> !running_reg && $stable(offset_reg) && $stable(pass_reg))
        else $error("sweep state moved after done");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_ready) |-> !pop)
        else $error("item consumed while result slot blocked");

endmodule

>>> test/tb_adc_window_stats_sweeper.sv
`timescale 1ns / 1ps

module tb_adc_window_stats_sweeper;

    // Tracks the sweep exactly as the block should: the register settings, the running
    // window statistics and the position in the sweep. Every closed window is stored
    // until the matching result transfer arrives.
    class sweep_tracker;
        int unsigned half_us_steps[12] = '{1, 2, 4, 6, 8, 10, 11, 12, 13, 14, 16, 20};

        logic [aws_pkg::ADC_BITS-1:0]   low_level  = aws_pkg::SAT_LOW_RESET;
        logic [aws_pkg::ADC_BITS-1:0]   high_level = aws_pkg::SAT_HIGH_RESET;
        logic [aws_pkg::COUNT_BITS-1:0] win_len    = aws_pkg::WINDOW_RESET;

        bit running = 1'b1;
        int pass_idx;
        int offset_idx;
        int sample_cnt;
        int lo;
        int hi;
        int total;
        int lo_sat;
        int hi_sat;
        int hs_cnt;
        int ls_cnt;
        int windows_closed;

        aws_pkg::result_t pending_windows[$];
        string            faults[$];

        function new();
            pass_idx = 0;
            offset_idx = 0;
            windows_closed = 0;
            clear_window();
        endfunction

        function void clear_window();
            sample_cnt = 0;
            lo = ((1 << aws_pkg::SAMPLE_BITS_DEF) - 1) & 12'hfff;
            hi = 0;
            total = 0;
            lo_sat = 0;
            hi_sat = 0;
            hs_cnt = 0;
            ls_cnt = 0;
        endfunction

        function logic [aws_pkg::TICK_BITS-1:0] ticks_at(int idx);
            return aws_pkg::TICK_BITS'(half_us_steps[idx] * aws_pkg::TICKS_PER_HALF_US);
        endfunction

        function void set_reg(logic [aws_pkg::CFG_INDEX_BITS-1:0] idx,
                              logic [aws_pkg::CFG_DATA_BITS-1:0] value);
            case (idx)
                aws_pkg::CFG_SAT_LOW:  low_level = value[aws_pkg::ADC_BITS-1:0];
                aws_pkg::CFG_SAT_HIGH: high_level = value[aws_pkg::ADC_BITS-1:0];
                aws_pkg::CFG_WINDOW:   win_len = value;
                default: ;
            endcase
        endfunction

        function void take_item(logic kind, logic [aws_pkg::ADC_BITS-1:0] adc, logic hs,
                                logic ls);
            int               v;
            aws_pkg::result_t r;
            if (!running)
                return;
            if (kind == aws_pkg::REQ_SNAPSHOT)
            begin
                if (hs && hs_cnt < 65535) hs_cnt++;
                if (ls && ls_cnt < 65535) ls_cnt++;
                return;
            end
            v = adc;
            if (v < lo) lo = v;
            if (v > hi) hi = v;
            total = (total + v > 28'hfffffff) ? 28'hfffffff : total + v;
            if (v <= int'(low_level) && lo_sat < 65535) lo_sat++;
            if (v >= int'(high_level) && hi_sat < 65535) hi_sat++;
            sample_cnt++;
            if (sample_cnt < int'(win_len))
                return;

            r.pass_number = aws_pkg::PASS_BITS'(pass_idx);
            r.offset_number = aws_pkg::OFFSET_BITS'(offset_idx);
            r.window_ticks = ticks_at(offset_idx);
            r.next_ticks = '0;
            r.sweep_done = 1'b0;
            if (offset_idx + 1 < aws_pkg::OFFSET_COUNT_DEF)
                r.next_ticks = ticks_at(offset_idx + 1);
            else if (pass_idx + 1 < aws_pkg::PASS_COUNT_DEF)
                r.next_ticks = ticks_at(0);
            else
                r.sweep_done = 1'b1;
            r.sample_min = aws_pkg::ADC_BITS'(lo);
            r.sample_max = aws_pkg::ADC_BITS'(hi);
            r.sample_sum = aws_pkg::SUM_BITS'(total);
            r.low_sat_count = aws_pkg::COUNT_BITS'(lo_sat);
            r.high_sat_count = aws_pkg::COUNT_BITS'(hi_sat);
            r.high_side_count = aws_pkg::COUNT_BITS'(hs_cnt);
            r.low_side_count = aws_pkg::COUNT_BITS'(ls_cnt);
            pending_windows.push_back(r);
            windows_closed++;

            if (r.sweep_done)
            begin
                running = 1'b0;
            end
            else if (offset_idx + 1 < aws_pkg::OFFSET_COUNT_DEF)
            begin
                offset_idx++;
            end
            else
            begin
                offset_idx = 0;
                pass_idx++;
            end
            clear_window();
        endfunction

        function void compare(string tag, string field, longint unsigned got,
                              longint unsigned want);
            if (got != want)
                faults.push_back($sformatf("%s %s: got %0d, expected %0d",
                                           tag, field, got, want));
        endfunction

        function void match_window(aws_pkg::result_t got);
            aws_pkg::result_t want;
            string            tag;
            if (pending_windows.size() == 0)
            begin
                faults.push_back("result transfer while no window was closed");
                return;
            end
            want = pending_windows.pop_front();
            tag = $sformatf("pass %0d offset %0d", want.pass_number, want.offset_number);
            compare(tag, "pass_number", got.pass_number, want.pass_number);
            compare(tag, "offset_number", got.offset_number, want.offset_number);
            compare(tag, "window_ticks", got.window_ticks, want.window_ticks);
            compare(tag, "next_ticks", got.next_ticks, want.next_ticks);
            compare(tag, "sample_min", got.sample_min, want.sample_min);
            compare(tag, "sample_max", got.sample_max, want.sample_max);
            compare(tag, "sample_sum", got.sample_sum, want.sample_sum);
            compare(tag, "low_sat_count", got.low_sat_count, want.low_sat_count);
            compare(tag, "high_sat_count", got.high_sat_count, want.high_sat_count);
            compare(tag, "high_side_count", got.high_side_count, want.high_side_count);
            compare(tag, "low_side_count", got.low_side_count, want.low_side_count);
            compare(tag, "sweep_done", got.sweep_done, want.sweep_done);
        endfunction
    endclass

    // All inputs of the block start at known values.
    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [15:0]                        s_tdata = '0;
    logic                               s_tuser = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [143:0]                       m_tdata;
    logic                               m_tlast;
    logic                               cfg_we = 1'b0;
    logic [aws_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [aws_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    sweep_tracker     tracker;
    aws_pkg::result_t seen_window;
    int               mismatches = 0;

    // When steady is set, neither side idles. hold_req asks the receiver for one long
    // hold-off; the receiver counts it down in its own process.
    bit steady = 1'b0;
    bit hold_req = 1'b0;
    bit hold_used = 1'b0;
    int hold_left = 0;
    int phase_no;

    adc_window_stats_sweeper u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(string msg);
        mismatches++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // Offers one item from the falling edge on and holds it until the transfer happens.
    // tvalid stays high into the next item unless a random idle cycle comes first.
    task automatic send_item(logic kind, logic [aws_pkg::ADC_BITS-1:0] adc, logic hs,
                             logic ls);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 7)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = {2'b00, ls, hs, adc};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.take_item(kind, adc, hs, ls);
    endtask

    // About three items in ten are pin snapshots. Samples lean now and then toward the
    // rails and the current thresholds so that the saturation compares are hit exactly.
    task automatic send_random_item();
        logic [aws_pkg::ADC_BITS-1:0] adc;
        logic                         hs;
        logic                         ls;
        adc = aws_pkg::ADC_BITS'($urandom);
        hs = 1'($urandom_range(0, 1));
        ls = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 30)
        begin
            send_item(aws_pkg::REQ_SNAPSHOT, adc, hs, ls);
        end
        else
        begin
            case ($urandom_range(0, 9))
                0: adc = '0;
                1: adc = '1;
                2: adc = tracker.low_level;
                3: adc = tracker.high_level;
                default: ;
            endcase
            send_item(aws_pkg::REQ_SAMPLE, adc, hs, ls);
        end
    endtask

    task automatic write_reg(logic [aws_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [aws_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        tracker.set_reg(idx, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Stops offering, waits for every closed window to come out, then lets snapshot and
    // sample transfers that close nothing drain through the front register, queue and back end.
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (tracker.pending_windows.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Result side: random ready with the occasional idle cycle, plus one long hold-off
    // that lets the internal queue fill and pushes back on the input side.
    always @(negedge clk)
    begin
        if (hold_req && !hold_used)
        begin
            hold_left = 200;
            hold_used = 1'b1;
        end
        if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left--;
        end
        else
        begin
            m_tready = steady || $urandom_range(0, 99) >= 7;
        end
    end

    // Every result transfer is unpacked from the bus layout and checked against the
    // oldest closed window.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_window.pass_number = m_tdata[1:0];
            seen_window.offset_number = m_tdata[5:2];
            seen_window.window_ticks = m_tdata[15:6];
            seen_window.next_ticks = m_tdata[25:16];
            seen_window.sample_min = m_tdata[37:26];
            seen_window.sample_max = m_tdata[49:38];
            seen_window.sample_sum = m_tdata[77:50];
            seen_window.low_sat_count = m_tdata[93:78];
            seen_window.high_sat_count = m_tdata[109:94];
            seen_window.high_side_count = m_tdata[125:110];
            seen_window.low_side_count = m_tdata[141:126];
            seen_window.sweep_done = m_tlast;
            tracker.match_window(seen_window);
            while (tracker.faults.size() != 0)
                report(tracker.faults.pop_front());
        end
    end

    initial
    begin
        tracker = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: samples right at and next to both default thresholds, the two
        // rails, and all four pin combinations. Random items then fill the 128 window.
        send_item(aws_pkg::REQ_SAMPLE, 12'd50, 1'b0, 1'b0);
        send_item(aws_pkg::REQ_SAMPLE, 12'd51, 1'b1, 1'b1);
        send_item(aws_pkg::REQ_SAMPLE, 12'd4045, 1'b0, 1'b0);
        send_item(aws_pkg::REQ_SAMPLE, 12'd4044, 1'b0, 1'b0);
        send_item(aws_pkg::REQ_SAMPLE, 12'd0, 1'b0, 1'b0);
        send_item(aws_pkg::REQ_SAMPLE, 12'd4095, 1'b0, 1'b0);
        send_item(aws_pkg::REQ_SNAPSHOT, 12'd0, 1'b0, 1'b0);
        send_item(aws_pkg::REQ_SNAPSHOT, 12'hfff, 1'b1, 1'b0);
        send_item(aws_pkg::REQ_SNAPSHOT, 12'd0, 1'b0, 1'b1);
        send_item(aws_pkg::REQ_SNAPSHOT, 12'hfff, 1'b1, 1'b1);
        while (tracker.windows_closed < 1)
            send_random_item();
        settle();

        // Windows of a single sample with the thresholds at opposite rails.
        write_reg(aws_pkg::CFG_SAT_LOW, 16'd0);
        write_reg(aws_pkg::CFG_SAT_HIGH, 16'd4095);
        write_reg(aws_pkg::CFG_WINDOW, 16'd1);
        send_item(aws_pkg::REQ_SAMPLE, 12'd0, 1'b0, 1'b0);
        send_item(aws_pkg::REQ_SNAPSHOT, 12'd0, 1'b1, 1'b1);
        send_item(aws_pkg::REQ_SAMPLE, 12'd4095, 1'b0, 1'b0);
        settle();

        // A window size of zero closes a window on every sample. The receiver holds off
        // meanwhile, so items back up in the queue behind the held result and the input stalls.
        write_reg(aws_pkg::CFG_SAT_LOW, 16'd4095);
        write_reg(aws_pkg::CFG_SAT_HIGH, 16'd0);
        write_reg(aws_pkg::CFG_WINDOW, 16'd0);
        @(posedge clk);
        hold_req = 1'b1;
        repeat (4) send_item(aws_pkg::REQ_SAMPLE, aws_pkg::ADC_BITS'($urandom), 1'b0, 1'b0);
        send_item(aws_pkg::REQ_SNAPSHOT, 12'd0, 1'b1, 1'b0);
        repeat (4) send_item(aws_pkg::REQ_SAMPLE, aws_pkg::ADC_BITS'($urandom), 1'b0, 1'b0);
        settle();

        // Full-scale samples after a run of snapshots: with both thresholds at their
        // extremes every sample raises the sum and both saturation counts; the first sets the maximum.
        write_reg(aws_pkg::CFG_WINDOW, 16'd40);
        repeat (45) send_item(aws_pkg::REQ_SNAPSHOT, aws_pkg::ADC_BITS'($urandom), 1'b1, 1'b1);
        repeat (40) send_item(aws_pkg::REQ_SAMPLE, 12'hfff, 1'b0, 1'b0);
        settle();

        // Random settings per phase, one to three windows each, until the sweep ends.
        // The first two phases run with no idling on either side.
        phase_no = 0;
        while (tracker.running)
        begin
            steady = (phase_no < 2);
            case ($urandom_range(0, 7))
                0: write_reg(aws_pkg::CFG_SAT_LOW, 16'd0);
                1: write_reg(aws_pkg::CFG_SAT_LOW, 16'd4095);
                default: write_reg(aws_pkg::CFG_SAT_LOW, 16'($urandom_range(0, 4095)));
            endcase
            case ($urandom_range(0, 7))
                0: write_reg(aws_pkg::CFG_SAT_HIGH, 16'd0);
                1: write_reg(aws_pkg::CFG_SAT_HIGH, 16'd4095);
                default: write_reg(aws_pkg::CFG_SAT_HIGH, 16'($urandom_range(0, 4095)));
            endcase
            if ($urandom_range(0, 9) == 0)
                write_reg(aws_pkg::CFG_WINDOW, 16'd1);
            else
                write_reg(aws_pkg::CFG_WINDOW, 16'($urandom_range(2, 60)));
            begin
                int target;
                target = tracker.windows_closed + $urandom_range(1, 3);
                while (tracker.running && tracker.windows_closed < target)
                    send_random_item();
            end
            settle();
            phase_no++;
        end
        steady = 1'b0;

        // After the last window the block must take and drop everything.
        repeat (20) send_random_item();
        settle();

        if (mismatches == 0)
            $display("adc_window_stats_sweeper verification clean");
        else
            $display("adc_window_stats_sweeper verification failed");
        $finish;
    end

    // Safety net far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("adc_window_stats_sweeper verification failed");
        $finish;
    end

endmodule
